// File: rtl/hss_pkg.sv
// Shared types, constants and helpers for the half-step stepper positioner.
package hss_pkg;

	localparam int ACTION_W = 2;
	localparam int TARGET_W = 24;
	localparam int POS_W    = 21;
	localparam int MAG_W    = 20;
	localparam int SPR_W    = 16;
	localparam int DELAY_W  = 16;
	localparam int COIL_W   = 4;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// degree conversion: |deg| * steps_per_rev, then /360 as >>3 and *recip(45)
	localparam int PROD_W      = TARGET_W + SPR_W;
	localparam int DIV8_SHIFT  = 3;
	localparam int BOUND_W     = 29;
	localparam int QIN_W       = BOUND_W - DIV8_SHIFT;
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 32;
	localparam int QPROD_W     = QIN_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP45     = 27'd95443718;
	localparam logic [8:0]         DEG_PER_REV = 9'd360;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STEP = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DEG  = 2'd2;

	localparam logic [1:0] REG_MAX_POS    = 2'd0;
	localparam logic [1:0] REG_STEPS_REV  = 2'd1;
	localparam logic [1:0] REG_STEP_DELAY = 2'd2;

	localparam logic [MAG_W-1:0]   MAX_POS_RST   = 20'hFFFFF;
	localparam logic [SPR_W-1:0]   STEPS_REV_RST = 16'd4096;
	localparam logic [DELAY_W-1:0] DELAY_RST     = 16'd2;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_SET,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [POS_W-1:0] target;
		logic                    clamped;
	} qent_t;

	typedef struct packed {
		logic [MAG_W-1:0]   max_position;
		logic [SPR_W-1:0]   steps_per_rev;
		logic [DELAY_W-1:0] step_delay;
	} cfg_t;

	function automatic logic [COIL_W-1:0] coil_pattern(input logic [2:0] phase);
		logic [COIL_W-1:0] pat;
		case (phase)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h1;
		endcase
		return pat;
	endfunction

endpackage

// File: rtl/hss_ifs.sv
// Request and result channel interfaces.
interface hss_cmd_if import hss_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [ACTION_W-1:0]         action;
	logic signed [TARGET_W-1:0]  target;

	modport source(output valid, action, target, input ready);
	modport sink(input valid, action, target, output ready);
endinterface

interface hss_res_if import hss_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [COIL_W-1:0]        coils;
	logic signed [POS_W-1:0]  position;
	logic                     moving;
	logic                     clamped;

	modport source(output valid, coils, position, moving, clamped, input ready);
	modport sink(input valid, coils, position, moving, clamped, output ready);
endinterface

// File: rtl/hss_cfg.sv
// APB register file: max_position, steps_per_rev, step_delay.
module hss_cfg import hss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_position  <= MAX_POS_RST;
			cfg_q.steps_per_rev <= STEPS_REV_RST;
			cfg_q.step_delay    <= DELAY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MAX_POS:    cfg_q.max_position  <= pwdata[MAG_W-1:0];
				REG_STEPS_REV:  cfg_q.steps_per_rev <= pwdata[SPR_W-1:0];
				REG_STEP_DELAY: cfg_q.step_delay    <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_POS:    prdata = {{(DATA_W-MAG_W){1'b0}}, cfg_q.max_position};
			REG_STEPS_REV:  prdata = {{(DATA_W-SPR_W){1'b0}}, cfg_q.steps_per_rev};
			REG_STEP_DELAY: prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_q.step_delay};
			default:        prdata = '0;
		endcase
	end

endmodule

// File: rtl/hss_front.sv
// Front end: classifies requests, converts degrees, clamps targets.
module hss_front import hss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	hss_cmd_if.sink cmd,
	input  cfg_t    cfg,
	output logic    push,
	output qent_t   push_ent,
	input  logic    full
);

	logic                adv;
	op_t                 op_in;
	logic [TARGET_W-1:0] mag_in;

	logic                v_s1, deg_s1, neg_s1;
	op_t                 op_s1;
	logic [TARGET_W-1:0] mag_s1;
	logic [PROD_W-1:0]   prod1;

	logic                v_s2, deg_s2, neg_s2;
	op_t                 op_s2;
	logic [PROD_W-1:0]   val_s2;
	logic [BOUND_W-1:0]  bound;
	logic                over;

	logic                v_s3, deg_s3, neg_s3, over_s3;
	op_t                 op_s3;
	logic [MAG_W-1:0]    stepv_s3;
	logic [QPROD_W-1:0]  quo_s3;
	logic [MAG_W-1:0]    mag_res;
	logic [POS_W-1:0]    mag_ext;

	// whole pipe advances unless the last stage is blocked on a full queue
	assign adv       = !v_s3 || !full;
	assign cmd.ready = adv;
	assign push      = v_s3 && !full;

	always_comb begin
		case (cmd.action)
			ACT_TICK:         op_in = OP_TICK;
			ACT_STEP, ACT_DEG: op_in = OP_SET;
			default:          op_in = OP_NOP;
		endcase
	end

	assign mag_in = cmd.target[TARGET_W-1] ? TARGET_W'(-cmd.target) : TARGET_W'(cmd.target);

	// magnitude times steps per revolution
	assign prod1 = {{SPR_W{1'b0}}, mag_s1} * {{TARGET_W{1'b0}}, cfg.steps_per_rev};

	// t > lim  <=>  floor(p/360) >= lim+1  <=>  p >= (lim+1)*360
	assign bound = ({{(BOUND_W-MAG_W){1'b0}}, cfg.max_position} + BOUND_W'(1))
		* BOUND_W'(DEG_PER_REV);

	always_comb begin
		if (deg_s2)
			over = val_s2 >= {{(PROD_W-BOUND_W){1'b0}}, bound};
		else
			over = val_s2 > {{(PROD_W-MAG_W){1'b0}}, cfg.max_position};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_in;
			deg_s1 <= cmd.action == ACT_DEG;
			neg_s1 <= cmd.target[TARGET_W-1];
			mag_s1 <= mag_in;

			op_s2  <= op_s1;
			deg_s2 <= deg_s1;
			neg_s2 <= neg_s1;
			val_s2 <= deg_s1 ? prod1 : {{SPR_W{1'b0}}, mag_s1};

			op_s3    <= op_s2;
			deg_s3   <= deg_s2;
			neg_s3   <= neg_s2;
			over_s3  <= over;
			stepv_s3 <= val_s2[MAG_W-1:0];
			// x/360 = (x>>3)/45, exact for the unclamped range
			quo_s3   <= {{RECIP_W{1'b0}}, val_s2[BOUND_W-1:DIV8_SHIFT]}
				* {{QIN_W{1'b0}}, RECIP45};
		end
	end

	always_comb begin
		if (over_s3)
			mag_res = cfg.max_position;
		else if (deg_s3)
			mag_res = quo_s3[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
		else
			mag_res = stepv_s3;
	end

	assign mag_ext          = {1'b0, mag_res};
	assign push_ent.op      = op_s3;
	assign push_ent.target  = neg_s3 ? -$signed(mag_ext) : $signed(mag_ext);
	assign push_ent.clamped = over_s3 && (op_s3 == OP_SET);

endmodule

// File: rtl/hss_fifo.sv
// Short queue between the front end and the motion back end.
module hss_fifo import hss_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t din,
	output logic  full,
	input  logic  pop,
	output qent_t dout,
	output logic  not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/hss_back.sv
// Back end: wait counter, position stepping and the result register.
module hss_back import hss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  qent_t     head,
	input  logic      head_valid,
	output logic      pop,
	hss_res_if.source res
);

	logic signed [POS_W-1:0] cur_q, tgt_q, cur_n, tgt_n;
	logic [DELAY_W-1:0]      wait_q, wait_n, wait_dec;

	logic                    ovalid_q;
	logic [COIL_W-1:0]       coils_q;
	logic signed [POS_W-1:0] pos_q;
	logic                    moving_q, clamped_q;

	assign pop = head_valid && (!ovalid_q || res.ready);

	always_comb begin
		cur_n    = cur_q;
		tgt_n    = tgt_q;
		wait_n   = wait_q;
		wait_dec = (wait_q != '0) ? wait_q - 1'b1 : '0;
		case (head.op)
			OP_SET: tgt_n = head.target;
			OP_TICK: begin
				wait_n = wait_dec;
				if (wait_dec == '0 && cur_q != tgt_q) begin
					cur_n  = (cur_q < tgt_q) ? cur_q + POS_W'(1) : cur_q - POS_W'(1);
					wait_n = cfg.step_delay;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			tgt_q    <= '0;
			wait_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_q  <= cur_n;
				tgt_q  <= tgt_n;
				wait_q <= wait_n;
			end
			if (pop)
				ovalid_q <= 1'b1;
			else if (res.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			coils_q   <= coil_pattern(cur_n[2:0]);
			pos_q     <= cur_n;
			moving_q  <= cur_n != tgt_n;
			clamped_q <= head.clamped;
		end
	end

	assign res.valid    = ovalid_q;
	assign res.coils    = coils_q;
	assign res.position = pos_q;
	assign res.moving   = moving_q;
	assign res.clamped  = clamped_q;

endmodule

// File: rtl/half_step_stepper_positioner_unit.sv
// A request passes through the 3 front stages, the queue and the result register before its result shows.
// Throughput: one request per cycle; the front stalls only while the queue is full.
// The front does the degree product in stage 1 and the /360 reciprocal multiply in stage 2.
// Reset (arst_n low, asynchronous): registers to defaults, position, target and wait
// count to zero, queue and pipeline empty. Usable as soon as reset is released.
module half_step_stepper_positioner_unit import hss_pkg::*; #(
	parameter int Q_DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	hss_cmd_if.sink           cmd,
	hss_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// the user must rewrite config only while no request is in flight; the block does not enforce this
	cfg_t  cfg;

	// front -> queue
	logic  q_push, q_full;
	qent_t q_in;

	// queue -> back
	logic  q_pop, q_nonempty;
	qent_t q_head;

	hss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// classify, convert degrees to half-steps, clamp
	hss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.push     (q_push),
		.push_ent (q_in),
		.full     (q_full)
	);

	// decouples the front pipeline from result back-pressure
	hss_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.dout      (q_head),
		.not_empty (q_nonempty)
	);

	// one queued entry per cycle into motion state and result register unless res is held
	hss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (q_head),
		.head_valid (q_nonempty),
		.pop        (q_pop),
		.res        (res)
	);

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");

	// only target-setting requests may carry the clamp flag
	a_clamp_set: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_in.clamped |-> q_in.op == OP_SET)
		else $error("clamp flag on non-set request");

	// every dequeue yields a visible result on the next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> res.valid)
		else $error("dequeue without result");

endmodule
